### hdl/mbet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, codes, control structs and the saturation helper.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int FX_W    = 32;
  localparam int PROD_W  = 64;
  localparam int STEP_W  = 21;
  localparam int LIMIT_W = 31;
  localparam int MAXIT_W = 11;
  localparam int PIX_W   = 10;
  localparam int ITER_W  = 10;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_RE_ORIGIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_IM_ORIGIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RE_STEP      = 3'd2;
  localparam logic [IDX_W-1:0] REG_IM_STEP      = 3'd3;
  localparam logic [IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_ITER     = 3'd5;

  // reset values, Q12.20
  localparam logic signed [FX_W-1:0] RST_RE_ORIGIN    = -32'sd2621440;
  localparam logic signed [FX_W-1:0] RST_IM_ORIGIN    = -32'sd1048576;
  localparam logic [STEP_W-1:0]      RST_RE_STEP      = 21'd4588;
  localparam logic [STEP_W-1:0]      RST_IM_STEP      = 21'd3495;
  localparam logic [LIMIT_W-1:0]     RST_ESCAPE_LIMIT = 31'd10485760;
  localparam logic [MAXIT_W-1:0]     RST_MAX_ITER     = 11'd256;

  localparam logic signed [PROD_W-1:0] FX_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] FX_MIN = -64'sd2147483648;

  localparam logic [ITER_W-1:0] RED_MUL  = 10'd6;
  localparam logic [ITER_W-1:0] BLUE_MUL = 10'd10;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MAP_RE  = 9'b000000010,
    ST_MAP_IM  = 9'b000000100,
    ST_MAP_FIN = 9'b000001000,
    ST_CHECK   = 9'b000010000,
    ST_MUL_YY  = 9'b000100000,
    ST_MUL_XY  = 9'b001000000,
    ST_UPDATE  = 9'b010000000,
    ST_FINISH  = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    MSEL_PX_RE = 3'd0,
    MSEL_PY_IM = 3'd1,
    MSEL_XX    = 3'd2,
    MSEL_YY    = 3'd3,
    MSEL_XY    = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic     ld_pix;
    mul_sel_e mul_sel;
    logic     ld_cre;
    logic     ld_cim;
    logic     init;
    logic     ld_xx;
    logic     ld_yy;
    logic     upd;
    logic     ld_out;
  } ctl_t;

  typedef struct packed {
    logic escaped;
    logic cap_hit;
  } stat_t;

  function automatic logic signed [FX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > FX_MAX) begin
      return FX_MAX[FX_W-1:0];
    end else if (v < FX_MIN) begin
      return FX_MIN[FX_W-1:0];
    end
    return v[FX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/mbet_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbet_mul
  import mbet_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [FX_W-1:0]   a_i,
  input  wire logic signed [FX_W-1:0]   b_i,
  output logic signed [PROD_W-1:0]      prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

### hdl/mbet_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot sequencer
// Steps the shared multiplier through point mapping and the z*z + c passes.
// ----------------------------------------------------------------------------
module mbet_ctrl
  import mbet_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output ctl_t       ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    ctl_o           = '0;
    ctl_o.mul_sel   = MSEL_XX;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.ld_pix = 1'b1;
          state_d      = ST_MAP_RE;
        end
      end
      ST_MAP_RE: begin
        ctl_o.mul_sel = MSEL_PX_RE;
        state_d       = ST_MAP_IM;
      end
      ST_MAP_IM: begin
        ctl_o.ld_cre  = 1'b1;
        ctl_o.mul_sel = MSEL_PY_IM;
        state_d       = ST_MAP_FIN;
      end
      ST_MAP_FIN: begin
        ctl_o.ld_cim = 1'b1;
        ctl_o.init   = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.escaped || stat_i.cap_hit) begin
          state_d = ST_FINISH;
        end else begin
          ctl_o.mul_sel = MSEL_XX;
          state_d       = ST_MUL_YY;
        end
      end
      ST_MUL_YY: begin
        ctl_o.ld_xx   = 1'b1;
        ctl_o.mul_sel = MSEL_YY;
        state_d       = ST_MUL_XY;
      end
      ST_MUL_XY: begin
        ctl_o.ld_yy   = 1'b1;
        ctl_o.mul_sel = MSEL_XY;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl_o.upd = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hdl/mbet_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot datapath
// Configuration registers, point mapping, z registers, count and result.
// ----------------------------------------------------------------------------
module mbet_dp
  import mbet_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int ITER_BOUND = 1024,
  parameter int FRAC_BITS  = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [FX_W-1:0]     cfg_data_i,
  input  wire logic [PIX_W-1:0]    pixel_x_i,
  input  wire logic [PIX_W-1:0]    pixel_y_i,
  input  wire ctl_t                ctl_i,
  output stat_t                    stat_o,
  output logic [ITER_W-1:0]        iter_count_o,
  output logic [COLOR_W-1:0]       red_o,
  output logic [COLOR_W-1:0]       blue_o
);

  localparam int CNT_W = $clog2(ITER_BOUND + 1);
  localparam logic [PIX_W-1:0] PX_CLAMP = PIX_W'(MAX_WIDTH - 1);
  localparam logic [PIX_W-1:0] PY_CLAMP = PIX_W'(MAX_HEIGHT - 1);

  logic signed [FX_W-1:0]   re_origin_q, im_origin_q;
  logic [STEP_W-1:0]        re_step_q, im_step_q;
  logic [LIMIT_W-1:0]       escape_limit_q;
  logic [MAXIT_W-1:0]       max_iter_q;

  logic [PIX_W-1:0]         px_q, py_q, px_d, py_d;
  logic [CNT_W-1:0]         cap_q, cap_d, count_q, fin_count;
  logic signed [FX_W-1:0]   cre_q, cim_q, x_q, y_q;
  logic signed [PROD_W-1:0] xx_q, yy_q, mag_q;
  logic [ITER_W-1:0]        iter_q, fin_iter;
  logic [COLOR_W-1:0]       red_q, blue_q;

  logic signed [FX_W-1:0]   mul_a, mul_b, map_origin;
  logic signed [PROD_W-1:0] prod, prod_sh, map_sum, limit_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_origin_q    <= RST_RE_ORIGIN;
      im_origin_q    <= RST_IM_ORIGIN;
      re_step_q      <= RST_RE_STEP;
      im_step_q      <= RST_IM_STEP;
      escape_limit_q <= RST_ESCAPE_LIMIT;
      max_iter_q     <= RST_MAX_ITER;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RE_ORIGIN:    re_origin_q    <= cfg_data_i;
        REG_IM_ORIGIN:    im_origin_q    <= cfg_data_i;
        REG_RE_STEP:      re_step_q      <= cfg_data_i[STEP_W-1:0];
        REG_IM_STEP:      im_step_q      <= cfg_data_i[STEP_W-1:0];
        REG_ESCAPE_LIMIT: escape_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_MAX_ITER:     max_iter_q     <= cfg_data_i[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp pixels and cap at accept
  assign px_d  = (32'(pixel_x_i) >= 32'(MAX_WIDTH))  ? PX_CLAMP : pixel_x_i;
  assign py_d  = (32'(pixel_y_i) >= 32'(MAX_HEIGHT)) ? PY_CLAMP : pixel_y_i;
  assign cap_d = (32'(max_iter_q) > 32'(ITER_BOUND)) ? CNT_W'(ITER_BOUND)
                                                     : CNT_W'(max_iter_q);

  always_comb begin
    case (ctl_i.mul_sel)
      MSEL_PX_RE: begin
        mul_a = FX_W'(px_q);
        mul_b = FX_W'(re_step_q);
      end
      MSEL_PY_IM: begin
        mul_a = FX_W'(py_q);
        mul_b = FX_W'(im_step_q);
      end
      MSEL_XX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      MSEL_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  mbet_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // arithmetic shift gives the floor of the scaled product
  assign prod_sh    = prod >>> FRAC_BITS;
  assign map_origin = ctl_i.ld_cre ? re_origin_q : im_origin_q;
  assign map_sum    = PROD_W'(map_origin) + prod;
  assign limit_ext  = $signed({{(PROD_W - LIMIT_W){1'b0}}, escape_limit_q});

  assign fin_count = (count_q == cap_q) ? '0 : count_q;
  assign fin_iter  = ITER_W'(fin_count);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_pix) begin
      px_q  <= px_d;
      py_q  <= py_d;
      cap_q <= cap_d;
    end
    if (ctl_i.ld_cre) begin
      cre_q <= sat32(map_sum);
    end
    if (ctl_i.ld_cim) begin
      cim_q <= sat32(map_sum);
    end
    if (ctl_i.init) begin
      x_q     <= '0;
      y_q     <= '0;
      mag_q   <= '0;
      count_q <= '0;
    end
    if (ctl_i.ld_xx) begin
      xx_q <= prod_sh;
    end
    if (ctl_i.ld_yy) begin
      yy_q <= prod_sh;
    end
    if (ctl_i.upd) begin
      y_q     <= sat32((prod_sh <<< 1) + PROD_W'(cim_q));
      x_q     <= sat32(xx_q - yy_q + PROD_W'(cre_q));
      mag_q   <= xx_q + yy_q;
      count_q <= CNT_W'(count_q + 1'b1);
    end
    if (ctl_i.ld_out) begin
      iter_q <= fin_iter;
      red_q  <= COLOR_W'(fin_iter * RED_MUL);
      blue_q <= COLOR_W'(fin_iter * BLUE_MUL);
    end
  end

  assign stat_o.escaped = (mag_q > limit_ext);
  assign stat_o.cap_hit = (count_q >= cap_q);

  assign iter_count_o = iter_q;
  assign red_o        = red_q;
  assign blue_o       = blue_q;

endmodule
`default_nettype wire

### hdl/mandelbrot_escape_time_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel evaluator
// Maps a pixel to c and iterates z = z*z + c, reporting the escape count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item: pixel_x_i, pixel_y_i.
//   Output channel (out_valid_o/out_ready_i) returns iter_count_o, red_o, blue_o.
//   Config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i with
//   cfg_data_i; it is always ready and should be used while the block is idle.
// Sequencing:
//   One signed 32x32 multiplier is shared by all products, so each pass runs
//   three products and then the z update. At most max_iter passes run, and
//   never more than ITER_BOUND. The next item is taken only once the result
//   has moved into the output register, which can wait on out_ready_i.
// Reset:
//   Registers return to the default window (-2.5..1.0 by -1.0..1.0 over 800x600
//   pixels), escape limit 10.0, cap 256; the block comes up ready, no result.
// Stall:
//   A result waits in the output register; a finished item waits in the finish
//   state until that register is free, and in_ready_o stays low meanwhile.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
  import mbet_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int ITER_BOUND = 1024,
  parameter int FRAC_BITS  = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [FX_W-1:0]   cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [PIX_W-1:0]  pixel_x_i,
  input  wire logic [PIX_W-1:0]  pixel_y_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ITER_W-1:0]      iter_count_o,
  output logic [COLOR_W-1:0]     red_o,
  output logic [COLOR_W-1:0]     blue_o
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  mbet_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ITER_BOUND (ITER_BOUND),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .iter_count_o (iter_count_o),
    .red_o        (red_o),
    .blue_o       (blue_o)
  );

endmodule
`default_nettype wire

### hdl/mbet_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module mbet_chk
  import mbet_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [ITER_W-1:0]  iter_count_o,
  input wire logic [COLOR_W-1:0] red_o,
  input wire logic [COLOR_W-1:0] blue_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(iter_count_o)
      && $stable(red_o) && $stable(blue_o))
    else $error("stalled result changed");

  // colors follow the count
  a_colors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o == COLOR_W'(iter_count_o * RED_MUL)
      && blue_o == COLOR_W'(iter_count_o * BLUE_MUL))
    else $error("color channels do not match count");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready while an item is in flight");

  // a new result only comes from a busy block
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind mandelbrot_escape_time_pixel mbet_chk u_mbet_chk (.*);
`default_nettype wire
